[hdl/h1rd_pkg.sv]
// Shared types and constants for the HTTP/1 response deframer.
package h1rd_pkg;

    localparam int MAX_LINE_DEF    = 65536;
    localparam int MAX_HEADERS_DEF = 500;
    localparam int MAX_INTERIM_DEF = 8;

    localparam logic [31:0] MAX_BODY_RESET = 32'd8388608;

    localparam logic [0:0] REG_MAX_BODY = 1'b0;
    localparam logic [0:0] REG_HEAD     = 1'b1;

    localparam logic [3:0] E_OK      = 4'd0;
    localparam logic [3:0] E_STATUS  = 4'd1;
    localparam logic [3:0] E_HEADER  = 4'd2;
    localparam logic [3:0] E_HDRS    = 4'd3;
    localparam logic [3:0] E_INTERIM = 4'd4;
    localparam logic [3:0] E_CSIZE   = 4'd5;
    localparam logic [3:0] E_CAP     = 4'd6;
    localparam logic [3:0] E_CEND    = 4'd7;
    localparam logic [3:0] E_LENGTH  = 4'd8;
    localparam logic [3:0] E_CLOSE   = 4'd9;
    localparam logic [3:0] E_LONG    = 4'd10;

    typedef enum logic [8:0] {
        PH_STATUS     = 9'b000000001,
        PH_HEADER     = 9'b000000010,
        PH_CSIZE      = 9'b000000100,
        PH_CDATA      = 9'b000001000,
        PH_CEND       = 9'b000010000,
        PH_TRAILER    = 9'b000100000,
        PH_BODY_LEN   = 9'b001000000,
        PH_BODY_CLOSE = 9'b010000000,
        PH_HALT       = 9'b100000000
    } t_phase;

    typedef enum logic [2:0] {
        VS_LEAD = 3'd0,
        VS_WORD = 3'd1,
        VS_TAIL = 3'd2,
        VS_FAIL = 3'd3,
        VS_EXT  = 3'd4
    } t_vstate;

    typedef enum logic [1:0] {
        K_NONE = 2'd0,
        K_TE   = 2'd1,
        K_CL   = 2'd2,
        K_CONN = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       body_valid;
        logic       response_done;
        logic [3:0] error_code;
        logic [9:0] status_code;
        logic       keep_alive;
        logic       is_http11;
    } t_result;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       peer_closed;
        logic       burst_end;
    } t_word;

    // Keyword text, index 0..5: chunked, close, keep-alive,
    // transfer-encoding, content-length, connection.
    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [4:0] p);
        string s;
        begin
            case (k)
                3'd0: s = "chunked";
                3'd1: s = "close";
                3'd2: s = "keep-alive";
                3'd3: s = "transfer-encoding";
                3'd4: s = "content-length";
                default: s = "connection";
            endcase
            if (int'(p) < s.len()) kw_char = s[p];
            else kw_char = 8'h00;
        end
    endfunction

    function automatic logic [4:0] kw_len(input logic [2:0] k);
        case (k)
            3'd0: kw_len = 5'd7;
            3'd1: kw_len = 5'd5;
            3'd2: kw_len = 5'd10;
            3'd3: kw_len = 5'd17;
            3'd4: kw_len = 5'd14;
            default: kw_len = 5'd10;
        endcase
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) to_lower = c + 8'd32;
        else to_lower = c;
    endfunction

    function automatic logic is_ows(input logic [7:0] c);
        is_ows = (c == 8'h20) || (c == 8'h09);
    endfunction

endpackage

[hdl/h1rd_stream_if.sv]
// Valid/ready stream channel carrying one word.
interface h1rd_stream_if #(parameter type T = logic [7:0]);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hdl/http1_response_deframer.sv]
// Top level of the HTTP/1 response deframer.
// Takes one received word (byte, close flag, burst-end flag) per cycle and produces at most one
// result word per input word: a body byte, an end-of-response report, or nothing. Each input word
// is registered, processed by one stage of byte-wide matchers and counters, and the result lands in
// an output register, so with the output drained a word is accepted every cycle. The input side
// stalls only while the output register holds a result the sink has not taken. Configuration (max
// body bytes at index 0, HEAD flag at index 1) must be written only while idle (not enforced).
// After any error other than an early close, the block drops all words until a close arrives.
module http1_response_deframer #(
    parameter int MAX_LINE    = h1rd_pkg::MAX_LINE_DEF,
    parameter int MAX_HEADERS = h1rd_pkg::MAX_HEADERS_DEF,
    parameter int MAX_INTERIM = h1rd_pkg::MAX_INTERIM_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    h1rd_stream_if.sink   i_in,
    h1rd_stream_if.source o_out
);
    localparam int LW = $clog2(MAX_LINE + 1);
    localparam int HW = $clog2(MAX_HEADERS + 2);
    localparam int IW = $clog2(MAX_INTERIM + 2);

    logic [31:0] r_max_body;
    logic        r_head;

    // input register
    logic             r_iv;
    h1rd_pkg::t_word  r_iw;
    // output register
    logic             r_ov;
    h1rd_pkg::t_result r_ow;

    h1rd_pkg::t_result res;
    logic              res_any;

    // advance the stage when the output slot is free or drained this cycle
    logic adv;
    assign adv = !r_ov || o_out.ready;
    assign i_in.ready = adv || !r_iv;
    assign o_out.valid = r_ov;
    assign o_out.data  = r_ow;

    // state
    h1rd_pkg::t_phase  r_phase, n_phase;
    logic [LW-1:0]     r_len, n_len;
    logic [4:0]        r_mpos, n_mpos;
    logic [2:0]        r_mflags, n_mflags;
    logic [9:0]        r_status, n_status;
    logic              r_v11, n_v11;
    logic [HW-1:0]     r_hcnt, n_hcnt;
    logic [IW-1:0]     r_icnt, n_icnt;
    logic [4:0]        r_ff, n_ff;
    logic [35:0]       r_lacc, n_lacc;
    logic [32:0]       r_bcnt, n_bcnt;
    logic [35:0]       r_crem, n_crem;
    logic              r_pcr, n_pcr;
    logic [3:0]        r_lerr, n_lerr;
    logic              r_colon, n_colon;
    h1rd_pkg::t_kind   r_kind, n_kind;
    h1rd_pkg::t_vstate r_vs, n_vs;
    logic [3:0]        r_clerr, n_clerr;
    logic              r_dseen, n_dseen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_body <= h1rd_pkg::MAX_BODY_RESET;
            r_head <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                h1rd_pkg::REG_MAX_BODY: r_max_body <= i_cfg_data;
                h1rd_pkg::REG_HEAD: r_head <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_iv <= 1'b1;
        end else if (adv) begin
            r_iv <= 1'b0;
        end
        if (i_in.valid && i_in.ready) r_iw <= i_in.data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= r_iv && res_any;
        end
        if (adv && r_iv) r_ow <= res;
    end

    // per-word processing
    always_comb begin
        logic [7:0] c, lc, cc;
        logic [LW-1:0] p, ln;
        logic fin_ok, fin_keep, do_fail, do_clear, clr_line, clr_hdr, body;
        logic [3:0] fcode;
        logic is_chr, run;
        logic [4:0] hx;
        logic hexok;
        logic [36:0] csum;
        logic interim;
        c = r_iw.in_byte;
        n_phase = r_phase; n_len = r_len; n_mpos = r_mpos; n_mflags = r_mflags;
        n_status = r_status; n_v11 = r_v11; n_hcnt = r_hcnt; n_icnt = r_icnt;
        n_ff = r_ff; n_lacc = r_lacc; n_bcnt = r_bcnt; n_crem = r_crem;
        n_pcr = r_pcr; n_lerr = r_lerr; n_colon = r_colon; n_kind = r_kind;
        n_vs = r_vs; n_clerr = r_clerr; n_dseen = r_dseen;
        fin_ok = 1'b0; fin_keep = 1'b0; do_fail = 1'b0; fcode = h1rd_pkg::E_OK;
        do_clear = 1'b0; clr_line = 1'b0; clr_hdr = 1'b0; body = 1'b0;
        run = 1'b0; cc = c; p = r_len; is_chr = 1'b0; ln = r_len;
        lc = 8'h00; hx = 5'd0; hexok = 1'b0; csum = '0; interim = 1'b0;

        if (r_iw.peer_closed) begin
            if (r_phase == h1rd_pkg::PH_BODY_CLOSE) fin_ok = 1'b1;
            else if (r_phase == h1rd_pkg::PH_HALT) do_clear = 1'b1;
            else begin do_fail = 1'b1; fcode = h1rd_pkg::E_CLOSE; end
        end else begin
            case (r_phase)
                h1rd_pkg::PH_HALT: ;
                h1rd_pkg::PH_CDATA: begin
                    body = 1'b1;
                    n_crem = r_crem - 36'd1;
                    if (r_crem == 36'd1) begin
                        clr_line = 1'b1; n_phase = h1rd_pkg::PH_CEND;
                    end
                end
                h1rd_pkg::PH_BODY_LEN: begin
                    body = 1'b1;
                    n_crem = r_crem - 36'd1;
                    if (r_crem == 36'd1) begin fin_ok = 1'b1; fin_keep = r_iw.burst_end; end
                end
                h1rd_pkg::PH_BODY_CLOSE: begin
                    if (r_bcnt >= {1'b0, r_max_body}) begin
                        do_fail = 1'b1; fcode = h1rd_pkg::E_CAP;
                    end else begin
                        body = 1'b1; n_bcnt = r_bcnt + 33'd1;
                    end
                end
                default: run = 1'b1;
            endcase
        end

        if (run) begin
            if (c == 8'h0A) begin
                ln = r_len - (r_pcr ? LW'(1) : LW'(0));
                case (r_phase)
                    h1rd_pkg::PH_STATUS: begin
                        if (r_lerr != 4'd0 || ln < LW'(12)) begin
                            do_fail = 1'b1; fcode = h1rd_pkg::E_STATUS;
                        end else begin
                            clr_line = 1'b1; n_phase = h1rd_pkg::PH_HEADER;
                        end
                    end
                    h1rd_pkg::PH_HEADER: begin
                        if (ln == '0) begin
                            interim = r_status >= 10'd100 && r_status < 10'd200 &&
                                      r_status != 10'd101;
                            if (interim) begin
                                n_icnt = r_icnt + IW'(1);
                                if (int'(r_icnt) + 1 > MAX_INTERIM) begin
                                    do_fail = 1'b1; fcode = h1rd_pkg::E_INTERIM;
                                end else begin
                                    clr_hdr = 1'b1; clr_line = 1'b1;
                                    n_status = '0; n_v11 = 1'b0;
                                    n_phase = h1rd_pkg::PH_STATUS;
                                end
                            end else if (r_head || r_status == 10'd204 || r_status == 10'd304)
                            begin
                                fin_ok = 1'b1; fin_keep = r_iw.burst_end;
                            end else begin
                                clr_line = 1'b1;
                                if (r_ff[1]) begin
                                    n_phase = h1rd_pkg::PH_CSIZE;
                                    n_crem = '0; n_dseen = 1'b0;
                                end else if (r_ff[2]) begin
                                    if (r_clerr != 4'd0) begin
                                        do_fail = 1'b1; fcode = r_clerr;
                                    end else if (r_lacc > {4'd0, r_max_body}) begin
                                        do_fail = 1'b1; fcode = h1rd_pkg::E_CAP;
                                    end else if (r_lacc == '0) begin
                                        fin_ok = 1'b1; fin_keep = r_iw.burst_end;
                                    end else begin
                                        n_crem = r_lacc; n_phase = h1rd_pkg::PH_BODY_LEN;
                                    end
                                end else begin
                                    n_phase = h1rd_pkg::PH_BODY_CLOSE;
                                end
                            end
                        end else if (!r_colon || r_lerr != 4'd0) begin
                            do_fail = 1'b1; fcode = h1rd_pkg::E_HEADER;
                        end else begin
                            if (r_kind == h1rd_pkg::K_TE &&
                                (r_vs == h1rd_pkg::VS_WORD || r_vs == h1rd_pkg::VS_TAIL) &&
                                r_mflags[0] && r_mpos == h1rd_pkg::kw_len(3'd0))
                                n_ff[1] = 1'b1;
                            else if (r_kind == h1rd_pkg::K_CL && r_clerr == 4'd0 &&
                                     r_vs == h1rd_pkg::VS_LEAD)
                                n_clerr = h1rd_pkg::E_LENGTH;
                            else if (r_kind == h1rd_pkg::K_CONN &&
                                     (r_vs == h1rd_pkg::VS_WORD ||
                                      r_vs == h1rd_pkg::VS_TAIL)) begin
                                if (r_mflags[0] && r_mpos == h1rd_pkg::kw_len(3'd1))
                                    n_ff[3] = 1'b1;
                                else if (r_mflags[1] && r_mpos == h1rd_pkg::kw_len(3'd2))
                                    n_ff[4] = 1'b1;
                            end
                            n_hcnt = r_hcnt + HW'(1);
                            if (int'(r_hcnt) + 1 > MAX_HEADERS) begin
                                do_fail = 1'b1; fcode = h1rd_pkg::E_HDRS;
                            end else clr_line = 1'b1;
                        end
                    end
                    h1rd_pkg::PH_CSIZE: begin
                        csum = {1'b0, r_bcnt[32:0] + 33'd0, 3'd0} >> 3;
                        csum = 37'(r_bcnt) + 37'(r_crem);
                        if (r_lerr != 4'd0) begin do_fail = 1'b1; fcode = r_lerr; end
                        else if (!r_dseen) begin do_fail = 1'b1; fcode = h1rd_pkg::E_CSIZE; end
                        else if (r_crem == '0) begin
                            clr_line = 1'b1; n_phase = h1rd_pkg::PH_TRAILER;
                        end else if (csum > 37'(r_max_body)) begin
                            do_fail = 1'b1; fcode = h1rd_pkg::E_CAP;
                        end else begin
                            n_bcnt = csum[32:0]; n_phase = h1rd_pkg::PH_CDATA;
                        end
                    end
                    h1rd_pkg::PH_CEND: begin
                        if (ln != '0) begin do_fail = 1'b1; fcode = h1rd_pkg::E_CEND; end
                        else begin
                            clr_line = 1'b1; n_phase = h1rd_pkg::PH_CSIZE;
                            n_crem = '0; n_dseen = 1'b0;
                        end
                    end
                    default: begin
                        if (ln == '0) begin fin_ok = 1'b1; fin_keep = r_iw.burst_end; end
                        else clr_line = 1'b1;
                    end
                endcase
            end else begin
                // held CR goes out now, with this byte unless it is a CR; a new CR is held
                if (r_pcr) begin
                    cc = 8'h0D; p = r_len - LW'(1); is_chr = 1'b1;
                    n_pcr = (c == 8'h0D);
                end else if (c == 8'h0D) begin
                    n_pcr = 1'b1;
                end else begin
                    is_chr = 1'b1;
                end
                if (r_pcr && c != 8'h0D) begin
                    is_chr = 1'b1;
                end
                n_len = r_len + LW'(1);
                if (int'(r_len) + 1 >= MAX_LINE) begin
                    do_fail = 1'b1; fcode = h1rd_pkg::E_LONG;
                end
            end
        end

        // content character handling (CR+byte pair is handled as two chars below)
        if (run && c != 8'h0A && is_chr) begin
            content(cc, p);
            if (r_pcr && c != 8'h0D) content(c, r_len);
        end

        if (clr_line) begin
            n_len = '0; n_pcr = 1'b0; n_lerr = '0; n_mpos = '0; n_mflags = 3'b111;
            n_colon = 1'b0; n_kind = h1rd_pkg::K_NONE; n_vs = h1rd_pkg::VS_LEAD;
        end
        if (clr_hdr) begin
            n_hcnt = '0; n_ff = '0; n_clerr = '0; n_lacc = '0;
        end

        res = '0;
        res.body_byte = body ? c : 8'h00;
        res.body_valid = body;
        res_any = body || fin_ok || do_fail;
        if (fin_ok) begin
            res.response_done = 1'b1;
            res.status_code = r_status;
            res.is_http11 = r_v11;
            res.keep_alive = fin_keep && !r_ff[3] && (r_v11 || r_ff[4]);
        end else if (do_fail) begin
            res.response_done = 1'b1;
            res.error_code = fcode;
        end
        if (fin_ok || do_fail || do_clear) begin
            n_phase = (do_fail && fcode != h1rd_pkg::E_CLOSE) ? h1rd_pkg::PH_HALT
                                                             : h1rd_pkg::PH_STATUS;
            n_len = '0; n_pcr = 1'b0; n_lerr = '0; n_mpos = '0; n_mflags = 3'b111;
            n_colon = 1'b0; n_kind = h1rd_pkg::K_NONE; n_vs = h1rd_pkg::VS_LEAD;
            n_hcnt = '0; n_ff = '0; n_clerr = '0; n_lacc = '0;
            n_status = '0; n_v11 = 1'b0; n_icnt = '0; n_bcnt = '0; n_crem = '0;
            n_dseen = 1'b0;
        end
    end

    // Apply one content character to the line scratch state (works on n_* in place).
    function automatic void content(input logic [7:0] ch, input logic [LW-1:0] pos);
        logic [7:0] l;
        logic [4:0] hv;
        logic hok;
        l = h1rd_pkg::to_lower(ch);
        hv = 5'd0; hok = 1'b0;
        case (n_phase)
            h1rd_pkg::PH_STATUS: begin
                if (pos == LW'(7)) begin
                    if (ch == 8'h31) n_v11 = 1'b1;
                    else if (ch == 8'h30) n_v11 = 1'b0;
                    else n_lerr = h1rd_pkg::E_STATUS;
                end else if (pos < LW'(9)) begin
                    if (ch != pfx(pos[3:0])) n_lerr = h1rd_pkg::E_STATUS;
                end else if (pos < LW'(12)) begin
                    if (ch < 8'h30 || ch > 8'h39) n_lerr = h1rd_pkg::E_STATUS;
                    else n_status = 10'(n_status * 10'd10) + 10'(ch - 8'h30);
                end
            end
            h1rd_pkg::PH_HEADER: begin
                if (!n_colon) begin
                    if (ch != 8'h3A) begin
                        if (h1rd_pkg::is_ows(ch) && n_lerr == 4'd0)
                            n_lerr = h1rd_pkg::E_HEADER;
                        mchar(l, 3'd3, 2'd3);
                    end else begin
                        n_colon = 1'b1;
                        if (pos == '0) n_lerr = h1rd_pkg::E_HEADER;
                        else if (n_mflags[0] && n_mpos == h1rd_pkg::kw_len(3'd3)) begin
                            if (!n_ff[0]) begin n_ff[0] = 1'b1; n_kind = h1rd_pkg::K_TE; end
                        end else if (n_mflags[1] && n_mpos == h1rd_pkg::kw_len(3'd4)) begin
                            if (!n_ff[2]) begin
                                n_ff[2] = 1'b1; n_kind = h1rd_pkg::K_CL; n_lacc = '0;
                            end
                        end else if (n_mflags[2] && n_mpos == h1rd_pkg::kw_len(3'd5)) begin
                            n_kind = h1rd_pkg::K_CONN;
                        end
                        n_vs = h1rd_pkg::VS_LEAD; n_mpos = '0; n_mflags = '0;
                    end
                end else begin
                    case (n_kind)
                        h1rd_pkg::K_TE: tchar(l, ch, 3'd0, 2'd1);
                        h1rd_pkg::K_CL: begin
                            if (n_clerr == 4'd0) begin
                                if (h1rd_pkg::is_ows(ch)) begin
                                    if (n_vs == h1rd_pkg::VS_WORD) n_vs = h1rd_pkg::VS_TAIL;
                                end else if (ch >= 8'h30 && ch <= 8'h39 &&
                                             n_vs != h1rd_pkg::VS_TAIL) begin
                                    if (n_lacc > {4'd0, r_max_body})
                                        n_clerr = h1rd_pkg::E_CAP;
                                    else
                                        n_lacc = 36'(n_lacc * 36'd10) + 36'(ch - 8'h30);
                                    n_vs = h1rd_pkg::VS_WORD;
                                end else n_clerr = h1rd_pkg::E_LENGTH;
                            end
                        end
                        h1rd_pkg::K_CONN: begin
                            if (ch == 8'h2C) begin
                                if (n_vs == h1rd_pkg::VS_WORD || n_vs == h1rd_pkg::VS_TAIL)
                                begin
                                    if (n_mflags[0] && n_mpos == h1rd_pkg::kw_len(3'd1))
                                        n_ff[3] = 1'b1;
                                    else if (n_mflags[1] && n_mpos == h1rd_pkg::kw_len(3'd2))
                                        n_ff[4] = 1'b1;
                                end
                                n_vs = h1rd_pkg::VS_LEAD;
                            end else tchar(l, ch, 3'd1, 2'd2);
                        end
                        default: ;
                    endcase
                end
            end
            h1rd_pkg::PH_CSIZE: begin
                if (n_lerr == 4'd0 && n_vs != h1rd_pkg::VS_EXT) begin
                    if (ch == 8'h3B) n_vs = h1rd_pkg::VS_EXT;
                    else if (h1rd_pkg::is_ows(ch)) begin
                        if (n_vs == h1rd_pkg::VS_WORD) n_vs = h1rd_pkg::VS_TAIL;
                    end else begin
                        if (ch >= 8'h30 && ch <= 8'h39) begin hok = 1'b1; hv = 5'(ch - 8'h30); end
                        else if (l >= 8'h61 && l <= 8'h66) begin
                            hok = 1'b1; hv = 5'(l - 8'h57);
                        end
                        if (hok && n_vs != h1rd_pkg::VS_TAIL) begin
                            if (n_crem > {8'd0, r_max_body[31:4]})
                                n_lerr = h1rd_pkg::E_CAP;
                            else n_crem = {n_crem[31:0], hv[3:0]};
                            n_vs = h1rd_pkg::VS_WORD; n_dseen = 1'b1;
                        end else n_lerr = h1rd_pkg::E_CSIZE;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic logic [7:0] pfx(input logic [3:0] i);
        string s;
        s = "HTTP/1.1 ";
        pfx = s[i];
    endfunction

    function automatic void mchar(input logic [7:0] l, input logic [2:0] first,
                                  input logic [1:0] cnt);
        for (int k = 0; k < 3; k++) begin
            if (k < int'(cnt) && n_mflags[k] &&
                !(n_mpos < h1rd_pkg::kw_len(first + 3'(k)) &&
                  h1rd_pkg::kw_char(first + 3'(k), n_mpos) == l))
                n_mflags[k] = 1'b0;
        end
        if (n_mpos < 5'd31) n_mpos = n_mpos + 5'd1;
    endfunction

    function automatic void tchar(input logic [7:0] l, input logic [7:0] ch,
                                  input logic [2:0] first, input logic [1:0] cnt);
        if (h1rd_pkg::is_ows(ch)) begin
            if (n_vs == h1rd_pkg::VS_WORD) n_vs = h1rd_pkg::VS_TAIL;
        end else begin
            if (n_vs == h1rd_pkg::VS_LEAD) begin
                n_vs = h1rd_pkg::VS_WORD; n_mpos = '0;
                n_mflags = (cnt == 2'd1) ? 3'b001 : 3'b011;
            end
            if (n_vs == h1rd_pkg::VS_WORD) mchar(l, first, cnt);
            else n_vs = h1rd_pkg::VS_FAIL;
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= h1rd_pkg::PH_STATUS;
            r_len <= '0; r_mpos <= '0; r_mflags <= 3'b111; r_status <= '0; r_v11 <= 1'b0;
            r_hcnt <= '0; r_icnt <= '0; r_ff <= '0; r_lacc <= '0; r_bcnt <= '0;
            r_crem <= '0; r_pcr <= 1'b0; r_lerr <= '0; r_colon <= 1'b0;
            r_kind <= h1rd_pkg::K_NONE; r_vs <= h1rd_pkg::VS_LEAD; r_clerr <= '0;
            r_dseen <= 1'b0;
        end else if (adv && r_iv) begin
            r_phase <= n_phase; r_len <= n_len; r_mpos <= n_mpos; r_mflags <= n_mflags;
            r_status <= n_status; r_v11 <= n_v11; r_hcnt <= n_hcnt; r_icnt <= n_icnt;
            r_ff <= n_ff; r_lacc <= n_lacc; r_bcnt <= n_bcnt; r_crem <= n_crem;
            r_pcr <= n_pcr; r_lerr <= n_lerr; r_colon <= n_colon; r_kind <= n_kind;
            r_vs <= n_vs; r_clerr <= n_clerr; r_dseen <= n_dseen;
        end
    end
endmodule
